### sv/kpc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults for the k-mer position counter
// no dependencies; used by kpc_window, the core and the checker
package kpc_pkg;

  localparam int DEF_MAX_K      = 4;
  localparam int DEF_MAX_POS    = 64;
  localparam int DEF_COUNT_BITS = 32;

  localparam int SEQ_W = 7;
  localparam logic [SEQ_W-1:0] SEQPOS_MAX = 7'd127;

  localparam logic [2:0] KMER_LENGTH_RST         = 3'd2;
  localparam logic       POSITIONAL_MODE_RST     = 1'b1;
  localparam logic       PER_SEQUENCE_LENGTH_RST = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_KMER_LENGTH         = 2'd0,
    REG_POSITIONAL_MODE     = 2'd1,
    REG_PER_SEQUENCE_LENGTH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // window outcome for one pushed base
  typedef struct packed {
    logic             hit;
    logic [SEQ_W-1:0] start;
  } window_hit_t;

  function automatic base_t decode_base(input logic [7:0] ch);
    base_t b;
    b.ok = 1'b1;
    case (ch)
      "A", "a": b.code = 2'd0;
      "C", "c": b.code = 2'd1;
      "G", "g": b.code = 2'd2;
      "T", "t": b.code = 2'd3;
      default: begin
        b.ok   = 1'b0;
        b.code = 2'd0;
      end
    endcase
    return b;
  endfunction

endpackage

### sv/kpc_window.sv
`timescale 1ns / 1ps
// sliding base window, valid run and sequence position tracking
// depends on kpc_pkg
module kpc_window #(
  parameter int MAX_K = kpc_pkg::DEF_MAX_K,
  localparam int CODE_W = 2 * MAX_K,
  localparam int KW = $clog2(MAX_K + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [7:0]                base_char,
  input  logic                      seq_end,
  input  logic [KW-1:0]             k,
  input  logic                      per_sequence_length,
  output kpc_pkg::window_hit_t      hit,
  output logic [CODE_W-1:0]         code
);

  logic [CODE_W-1:0]         window;
  logic [KW-1:0]             run;
  logic [kpc_pkg::SEQ_W-1:0] seq_pos;
  logic [kpc_pkg::SEQ_W-1:0] first_wc;
  logic                      first_done;

  kpc_pkg::base_t            base;
  logic [CODE_W-1:0]         win_shift;
  logic [CODE_W-1:0]         mask;
  logic [KW-1:0]             run_upd;
  logic [7:0]                seq1;
  logic [7:0]                k8;
  logic [kpc_pkg::SEQ_W-1:0] start;
  logic [kpc_pkg::SEQ_W-1:0] seq_sat;
  logic [kpc_pkg::SEQ_W-1:0] fwc_new;
  logic                      allowed;

  always_comb begin
    base      = kpc_pkg::decode_base(base_char);
    win_shift = CODE_W'({window, base.code});
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = {2{KW'(i) < k}};
    end
    code    = win_shift & mask;
    run_upd = (run < k) ? KW'(run + 1'b1) : k;
    seq1    = {1'b0, seq_pos} + 8'd1;
    k8      = 8'(k);
    start   = kpc_pkg::SEQ_W'(seq1 - k8);
    allowed = per_sequence_length | ~first_done | (start < first_wc);
    hit.hit   = base.ok & (run_upd >= k) & (seq1 >= k8) & allowed;
    hit.start = start;
    seq_sat = (seq_pos < kpc_pkg::SEQPOS_MAX) ? kpc_pkg::SEQ_W'(seq_pos + 1'b1) : seq_pos;
    // window count of a sequence that ends here
    fwc_new = ({1'b0, seq_sat} >= k8) ?
              kpc_pkg::SEQ_W'({1'b0, seq_sat} - k8 + 8'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      run        <= '0;
      seq_pos    <= '0;
      first_wc   <= '0;
      first_done <= 1'b0;
    end else if (push) begin
      if (seq_end) begin
        window  <= '0;
        run     <= '0;
        seq_pos <= '0;
        if (!first_done) begin
          first_wc   <= fwc_new;
          first_done <= 1'b1;
        end
      end else begin
        if (base.ok) begin
          window <= win_shift;
          run    <= run_upd;
        end else begin
          run <= '0;
        end
        seq_pos <= seq_sat;
      end
    end
  end

endmodule

### sv/kmer_position_counter_core.sv
`timescale 1ns / 1ps
// k-mer counter core: one item per cycle while in_stall is low, counter
// read-modify-write over two synchronous tables with a one-deep write forward;
// a read beat passes the back stage, then the output register. reset, and
// every clear beat, run a clearing pass over every table entry with in_stall
// high; configuration writes are taken during the pass.
// depends on kpc_pkg and kpc_window
module kmer_position_counter_core #(
  parameter int MAX_K      = kpc_pkg::DEF_MAX_K,
  parameter int MAX_POS    = kpc_pkg::DEF_MAX_POS,
  parameter int COUNT_BITS = kpc_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  base_char,
  input  logic        seq_end,
  input  logic [7:0]  kmer_code,
  input  logic [5:0]  start_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] count,
  output logic        pos_in_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CODE_W    = 2 * MAX_K;
  localparam int NUM_CODES = 1 << CODE_W;
  localparam int POS_W     = $clog2(MAX_POS);
  localparam int PADDR_W   = CODE_W + POS_W;
  localparam int PDEPTH    = 1 << PADDR_W;
  localparam int KW        = $clog2(MAX_K + 1);

  // configuration
  logic [2:0] kmer_length;
  logic       positional_mode;
  logic       per_sequence_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length         <= kpc_pkg::KMER_LENGTH_RST;
      positional_mode     <= kpc_pkg::POSITIONAL_MODE_RST;
      per_sequence_length <= kpc_pkg::PER_SEQUENCE_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (kpc_pkg::reg_idx_t'(cfg_index))
        kpc_pkg::REG_KMER_LENGTH:         kmer_length         <= cfg_data[2:0];
        kpc_pkg::REG_POSITIONAL_MODE:     positional_mode     <= cfg_data[0];
        kpc_pkg::REG_PER_SEQUENCE_LENGTH: per_sequence_length <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0] k_eff;

  always_comb begin
    if (kmer_length == 3'd0) k_eff = KW'(1);
    else if (int'(kmer_length) > MAX_K) k_eff = KW'(MAX_K);
    else k_eff = KW'(kmer_length);
  end

  // front stage
  logic         accept;
  kpc_pkg::op_t op;
  logic         is_push, is_read, is_clear;

  assign accept = in_valid & ~in_stall;

  always_comb begin
    op       = kpc_pkg::op_t'(opcode);
    is_push  = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    case (op)
      kpc_pkg::OP_PUSH:  is_push  = 1'b1;
      kpc_pkg::OP_READ:  is_read  = 1'b1;
      kpc_pkg::OP_CLEAR: is_clear = 1'b1;
      default: ;
    endcase
  end

  kpc_pkg::window_hit_t w_hit;
  logic [CODE_W-1:0]    w_code;

  kpc_window #(
    .MAX_K(MAX_K)
  ) u_window (
    .clk                 (clk),
    .rst                 (rst),
    .push                (accept & is_push),
    .base_char           (base_char),
    .seq_end             (seq_end),
    .k                   (k_eff),
    .per_sequence_length (per_sequence_length),
    .hit                 (w_hit),
    .code                (w_code)
  );

  logic               pos_ok, push_pos, push_tot, rd_in_range;
  logic [PADDR_W-1:0] s0_paddr;
  logic [CODE_W-1:0]  s0_taddr;
  logic               s0_load, s0_fwd;

  // back stage
  logic                  s1_valid, s1_read, s1_use_pos, s1_in_range, s1_fwd;
  logic [PADDR_W-1:0]    s1_paddr;
  logic [CODE_W-1:0]     s1_taddr;
  logic                  s1_write, s1_blocked;
  logic [COUNT_BITS-1:0] s1_old, s1_inc;
  logic [COUNT_BITS-1:0] last_wr;

  always_comb begin
    pos_ok      = 32'(w_hit.start) < 32'(MAX_POS);
    push_pos    = is_push & w_hit.hit & positional_mode & pos_ok;
    push_tot    = is_push & w_hit.hit & ~positional_mode;
    rd_in_range = ~positional_mode | (32'(start_pos) < 32'(MAX_POS));
    s0_paddr    = is_read ? {CODE_W'(kmer_code), POS_W'(start_pos)}
                          : {w_code, POS_W'(w_hit.start)};
    s0_taddr    = is_read ? CODE_W'(kmer_code) : w_code;
    s0_load     = accept & (is_read | push_pos | push_tot);
    // counter being written this cycle is the one now read: take it from last_wr
    s0_fwd      = s1_write & (s1_use_pos == positional_mode) &
                  (s1_use_pos ? (s1_paddr == s0_paddr) : (s1_taddr == s0_taddr));
  end

  // clearing pass
  logic               clearing;
  logic [PADDR_W-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      sweep_addr <= '0;
    end else if (clearing) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (&sweep_addr) clearing <= 1'b0;
    end else if (accept && is_clear) begin
      clearing   <= 1'b1;
      sweep_addr <= '0;
    end
  end

  // count tables
  logic [COUNT_BITS-1:0] pos_mem [PDEPTH];
  logic [COUNT_BITS-1:0] tot_mem [NUM_CODES];
  logic [COUNT_BITS-1:0] pos_rd, tot_rd;
  logic                  pos_we, tot_we;
  logic [PADDR_W-1:0]    pos_waddr;
  logic [CODE_W-1:0]     tot_waddr;
  logic [COUNT_BITS-1:0] wdata;

  always_comb begin
    s1_write   = s1_valid & ~s1_read;
    s1_blocked = s1_valid & s1_read & out_valid & out_stall;
    s1_old     = s1_fwd ? last_wr : (s1_use_pos ? pos_rd : tot_rd);
    s1_inc     = (&s1_old) ? s1_old : s1_old + 1'b1;
    pos_we     = clearing | (s1_write & s1_use_pos);
    tot_we     = clearing | (s1_write & ~s1_use_pos);
    pos_waddr  = clearing ? sweep_addr : s1_paddr;
    tot_waddr  = clearing ? sweep_addr[PADDR_W-1 -: CODE_W] : s1_taddr;
    wdata      = clearing ? '0 : s1_inc;
  end

  assign in_stall = clearing | s1_blocked;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= wdata;
    if (accept) pos_rd <= pos_mem[s0_paddr];
  end

  always_ff @(posedge clk) begin
    if (tot_we) tot_mem[tot_waddr] <= wdata;
    if (accept) tot_rd <= tot_mem[s0_taddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_blocked) begin
      s1_valid <= s0_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_blocked) begin
      s1_read     <= is_read;
      s1_use_pos  <= positional_mode;
      s1_in_range <= rd_in_range;
      s1_fwd      <= s0_fwd;
      s1_paddr    <= s0_paddr;
      s1_taddr    <= s0_taddr;
    end
    if (s1_write) last_wr <= s1_inc;
  end

  // output register
  logic                  out_load;
  logic [COUNT_BITS-1:0] out_cnt;

  assign out_load = s1_valid & s1_read & ~s1_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cnt      <= s1_in_range ? s1_old : '0;
      pos_in_range <= s1_in_range;
    end
  end

  assign count = 32'(out_cnt);

endmodule

### sv/kpc_checker.sv
`timescale 1ns / 1ps
// port-level checks for kmer_position_counter_core, bound into that module
// depends on kpc_pkg and kmer_position_counter_core
module kpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] count,
  input logic        pos_in_range
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(count) && $stable(pos_in_range))
    else $error("result beat changed while stalled");

  // reset starts the clearing pass
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken right after reset");

  // a clear beat starts the clearing pass
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == kpc_pkg::OP_CLEAR |=> in_stall)
    else $error("input taken right after clear");

  // a position outside the table reads as zero
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pos_in_range |-> count == 32'd0)
    else $error("nonzero count for position outside table");

  // a fresh result comes from an accepted read beat, registered through the back stage
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && opcode == kpc_pkg::OP_READ, 2))
    else $error("result beat without a read");

endmodule

bind kmer_position_counter_core kpc_checker u_kpc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .opcode       (opcode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .count        (count),
  .pos_in_range (pos_in_range)
);
